// ===== hw/rtl/cpt_pkg.sv =====
`default_nettype none
// ============================================================================
// cpt_pkg
// Shared types and constants of the confirmation percentile tracker.
// ============================================================================
package cpt_pkg;

	localparam int CPT_MAX_SIGNERS = 32;

	localparam int SLOT_W = 5;
	localparam int BLK_W = 32;
	localparam int CNT_W = 6;
	localparam int THR_W = 14;
	localparam int PROD_W = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [THR_W-1:0] FULL_SHARE = 14'd10000;
	localparam logic [CNT_W-1:0] ACTIVE_COUNT_RST = 6'd1;
	localparam logic [THR_W-1:0] THRESHOLD_RST = 14'd7000;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OFFSET,
		ST_SWEEP,
		ST_DRAIN,
		ST_CHECK
	} cpt_state_t;

	typedef struct packed {
		logic [SLOT_W-1:0] signer_slot;
		logic [BLK_W-1:0] block_number;
	} cpt_in_t;

	typedef struct packed {
		logic [BLK_W-1:0] finality_mark;
		logic advanced;
	} cpt_out_t;

	typedef struct packed {
		logic clr;
		logic acc;
	} rank_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] below;
		logic [CNT_W-1:0] upto;
	} rank_cnt_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cpt_ram.sv =====
`default_nettype none
// ============================================================================
// cpt_ram
// Generic RAM with one write port and two registered read ports.
// ============================================================================
module cpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [ADDR_W-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [ADDR_W-1:0] raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input wire logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cpt_offset.sv =====
`default_nettype none
// ============================================================================
// cpt_offset
// Selection rank from threshold and signer count, divided by repeated subtraction.
// ============================================================================
module cpt_offset
	import cpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [CNT_W-1:0] count,
	input wire logic [THR_W-1:0] threshold,
	output logic done,
	output logic [CNT_W-1:0] offset
);

	logic [THR_W-1:0] thr_eff;
	logic [THR_W-1:0] diff;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] acc_q;
	logic [CNT_W-1:0] q_q;
	logic [CNT_W-1:0] n_q;
	logic busy_q;
	logic more;

	always_comb begin
		if (threshold == '0) begin
			thr_eff = THR_W'(1);
		end else if (threshold > FULL_SHARE) begin
			thr_eff = FULL_SHARE;
		end else begin
			thr_eff = threshold;
		end
		diff = FULL_SHARE - thr_eff;
		prod = PROD_W'(diff) * PROD_W'(count);
		more = acc_q >= PROD_W'(FULL_SHARE);
	end

	assign done = busy_q && !more;
	assign offset = (q_q >= n_q) ? n_q - CNT_W'(1) : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			acc_q <= '0;
			q_q <= '0;
			n_q <= CNT_W'(1);
		end else if (start) begin
			busy_q <= 1'b1;
			acc_q <= prod;
			q_q <= '0;
			n_q <= count;
		end else if (busy_q) begin
			if (more) begin
				acc_q <= acc_q - PROD_W'(FULL_SHARE);
				q_q <= q_q + CNT_W'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cpt_rank.sv =====
`default_nettype none
// ============================================================================
// cpt_rank
// Counts table entries below and up to the candidate value during a sweep.
// ============================================================================
module cpt_rank
	import cpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire rank_ctl_t ctl,
	input wire logic [BLK_W-1:0] cand,
	input wire logic [BLK_W-1:0] other,
	output rank_cnt_t cnt
);

	rank_cnt_t cnt_q;

	assign cnt = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clr) begin
			cnt_q <= '0;
		end else if (ctl.acc) begin
			cnt_q.below <= cnt_q.below + CNT_W'(other < cand);
			cnt_q.upto <= cnt_q.upto + CNT_W'(other <= cand);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/confirmation_percentile_tracker.sv =====
`default_nettype none
// ============================================================================
// confirmation_percentile_tracker
// Stores each signer's confirmed block and raises the finality mark to the
// selected order statistic of the active signers.
// ============================================================================
//  Port group      Dir   Handshake              Contents
//  in_*            in    in_valid / in_ready    cpt_in_t: signer_slot, block_number
//  out_*           out   out_valid / out_ready  cpt_out_t: finality_mark, advanced
//  cfg_*           in    cfg_we                 cfg_index, cfg_data
//
//  An item is accepted, its rank offset q is found by repeated subtraction, and then
//  candidates (at most n, the active count) are tried in turn, each with a rank
//  sweep over the table's two read ports followed by a drain and a check step.
//  After reset a clearing pass writes zero to all MAX_SIGNERS entries, one per cycle.
//  A result waits in the output register while the next transfer is taken.
// ============================================================================
module confirmation_percentile_tracker
	import cpt_pkg::*;
#(
	parameter int MAX_SIGNERS = CPT_MAX_SIGNERS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire cpt_in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output cpt_out_t out_data,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = (MAX_SIGNERS > 1) ? $clog2(MAX_SIGNERS) : 1;
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_SIGNERS - 1);

	cpt_state_t state_q, state_d;
	logic [CNT_W-1:0] ac_q;
	logic [THR_W-1:0] thr_q;
	logic [CNT_W-1:0] i_q, j_q, n_q, k_q;
	logic [ADDR_W-1:0] clr_q;
	logic rd_vld_s1;
	logic [BLK_W-1:0] final_q;
	logic out_valid_q;
	cpt_out_t out_q;

	logic [CNT_W-1:0] n_eff;
	logic slot_ok;
	logic accept;
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [BLK_W-1:0] ram_wdata;
	logic [BLK_W-1:0] rd_a, rd_b;
	logic ofs_start, ofs_done;
	logic [CNT_W-1:0] ofs_offset;
	rank_ctl_t rank_ctl;
	rank_cnt_t rank_cnt;
	logic hit, last_i, out_free, finish;
	logic [BLK_W-1:0] cand;

	cpt_ram #(
		.WIDTH(BLK_W),
		.DEPTH(MAX_SIGNERS),
		.ADDR_W(ADDR_W)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr_a(ADDR_W'(i_q)),
		.rdata_a(rd_a),
		.raddr_b(ADDR_W'(j_q)),
		.rdata_b(rd_b)
	);

	cpt_offset u_offset (
		.clk(clk),
		.arst_n(arst_n),
		.start(ofs_start),
		.count(n_eff),
		.threshold(thr_q),
		.done(ofs_done),
		.offset(ofs_offset)
	);

	cpt_rank u_rank (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(rank_ctl),
		.cand(rd_a),
		.other(rd_b),
		.cnt(rank_cnt)
	);

	always_comb begin
		if (ac_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(ac_q) > 32'(MAX_SIGNERS)) begin
			n_eff = CNT_W'(MAX_SIGNERS);
		end else begin
			n_eff = ac_q;
		end
		slot_ok = 32'(in_data.signer_slot) < 32'(MAX_SIGNERS);
		hit = (rank_cnt.below <= k_q) && (k_q < rank_cnt.upto);
		last_i = i_q == n_q - CNT_W'(1);
		out_free = !out_valid_q || out_ready;
		cand = hit ? rd_a : '0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_OFFSET;
				end
			end
			ST_OFFSET: begin
				if (ofs_done) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (j_q == n_q - CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (hit || last_i) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_SWEEP;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = ADDR_W'(in_data.signer_slot);
		ram_wdata = in_data.block_number;
		ofs_start = 1'b0;
		rank_ctl.clr = 1'b1;
		rank_ctl.acc = 1'b0;
		finish = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				ram_we = in_valid && slot_ok;
				ofs_start = in_valid;
			end
			ST_SWEEP, ST_DRAIN: begin
				rank_ctl.clr = 1'b0;
				rank_ctl.acc = rd_vld_s1;
			end
			ST_CHECK: begin
				rank_ctl.clr = !(hit || last_i);
				finish = (hit || last_i) && out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ac_q <= ACTIVE_COUNT_RST;
			thr_q <= THRESHOLD_RST;
			i_q <= '0;
			j_q <= '0;
			n_q <= CNT_W'(1);
			k_q <= '0;
			clr_q <= '0;
			rd_vld_s1 <= 1'b0;
			final_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= state_q == ST_SWEEP;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACTIVE_COUNT: ac_q <= cfg_data[CNT_W-1:0];
					CFG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (accept) begin
				n_q <= n_eff;
				i_q <= '0;
				j_q <= '0;
			end
			if (state_q == ST_OFFSET && ofs_done) begin
				k_q <= ofs_offset;
			end
			if (state_q == ST_SWEEP) begin
				j_q <= (j_q == n_q - CNT_W'(1)) ? '0 : j_q + CNT_W'(1);
			end
			if (state_q == ST_CHECK && !(hit || last_i)) begin
				i_q <= i_q + CNT_W'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				if (cand > final_q) begin
					final_q <= cand;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.finality_mark <= (cand > final_q) ? cand : final_q;
			out_q.advanced <= cand > final_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_mark_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> final_q >= $past(final_q))
		else $error("Finality mark moved back.");

	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> rank_cnt.upto >= rank_cnt.below)
		else $error("Rank counts out of order.");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> k_q < n_q)
		else $error("Selection rank not below signer count.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_CHECK)
		else $error("Result raised outside the check step.");

endmodule
`default_nettype wire
